### rtl/core/spdg_pkg.sv
package spdg_pkg;

  // Field widths on the ports.
  localparam int VERTEX_PORT_BITS = 4;
  localparam int WEIGHT_PORT_BITS = 8;
  localparam int DIST_PORT_BITS   = 12;

  // Default sizing of the graph.
  localparam int DEFAULT_VERTICES    = 16;
  localparam int DEFAULT_WEIGHT_BITS = 8;

  // Stored distances never exceed infinity, so 14 bits hold them all.
  localparam int                DIST_BITS     = 14;
  localparam logic [DIST_BITS-1:0] DIST_INF   = 14'd9999;
  localparam logic [DIST_BITS-1:0] DIST_OUT_MAX = 14'd4095;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_RUN   = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_RELAX,
    ST_EMIT
  } state_e;

  // Start request handed from the input side to the search sequencer.
  typedef struct packed {
    logic                        run;
    logic [VERTEX_PORT_BITS-1:0] src;
  } run_req_t;

endpackage

### rtl/core/shortest_path_dense_graph_top.sv
// Single-source shortest paths over a dense directed graph held as a weight matrix.
// Input channel (in_valid_i / in_stall_o): a write word (req_type 0) stores one
// edge weight at (from_vertex, to_vertex); weight 0 means no edge, and a write
// outside the graph is dropped. A run word (req_type 1) searches from source_vertex.
// Output channel (out_valid_o / out_stall_i): after a run, one word per vertex in
// index order, with last_result_o set on the final one.
// Writes: a write leaves the input free, so words can be taken back to back.
// A run searches the matrix in rounds: each round scans all distances for the
// nearest unsettled vertex, marks it settled in the pick step, then relaxes its
// matrix row through the registered memory read. At most VERTICES-1 rounds,
// fewer once no finite distance is left to settle; then the results follow, one
// result per cycle unless stalled.
// The input is stalled for the whole run and while results are emitted.
// Reset: the matrix is swept to zero, one entry per cycle, over all
// VERTICES*VERTICES entries; the input is stalled until the sweep ends.
// A stalled output word holds, and so does the emission; the search does not wait,
// and the last output word may still be waiting while the next input word is taken.
module shortest_path_dense_graph_top #(
  parameter int VERTICES    = spdg_pkg::DEFAULT_VERTICES,
  parameter int WEIGHT_BITS = spdg_pkg::DEFAULT_WEIGHT_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   req_type_i,
  input  logic [spdg_pkg::VERTEX_PORT_BITS-1:0]  from_vertex_i,
  input  logic [spdg_pkg::VERTEX_PORT_BITS-1:0]  to_vertex_i,
  input  logic [spdg_pkg::WEIGHT_PORT_BITS-1:0]  edge_weight_i,
  input  logic [spdg_pkg::VERTEX_PORT_BITS-1:0]  source_vertex_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [spdg_pkg::VERTEX_PORT_BITS-1:0]  vertex_index_o,
  output logic [spdg_pkg::DIST_PORT_BITS-1:0]    path_distance_o,
  output logic                                   reachable_o,
  output logic                                   last_result_o
);

  localparam int VIDX_BITS = $clog2(VERTICES);
  localparam int ADDR_BITS = $clog2(VERTICES * VERTICES);

  logic                   accept;
  logic                   core_idle;
  logic                   clearing;
  logic                   wr_en;
  logic [ADDR_BITS-1:0]   wr_addr;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  spdg_pkg::run_req_t     run_req;

  assign in_stall_o = clearing || !core_idle;
  assign accept     = in_valid_i && !in_stall_o;

  assign wr_en   = accept && (req_type_i == spdg_pkg::REQ_WRITE) &&
                   (int'(from_vertex_i) < VERTICES) && (int'(to_vertex_i) < VERTICES);
  assign wr_addr = ADDR_BITS'(VIDX_BITS'(from_vertex_i)) * ADDR_BITS'(VERTICES) +
                   ADDR_BITS'(VIDX_BITS'(to_vertex_i));

  assign run_req.run = accept && (req_type_i == spdg_pkg::REQ_RUN);
  assign run_req.src = source_vertex_i;

  spdg_wmem #(
    .VERTICES    (VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_wmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (WEIGHT_BITS'(edge_weight_i)),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  spdg_core #(
    .VERTICES    (VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .run_i           (run_req),
    .idle_o          (core_idle),
    .mem_rd_addr_o   (rd_addr),
    .mem_rd_data_i   (rd_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_index_o  (vertex_index_o),
    .path_distance_o (path_distance_o),
    .reachable_o     (reachable_o),
    .last_result_o   (last_result_o)
  );

endmodule

### rtl/core/spdg_wmem.sv
module spdg_wmem #(
  parameter int VERTICES    = spdg_pkg::DEFAULT_VERTICES,
  parameter int WEIGHT_BITS = spdg_pkg::DEFAULT_WEIGHT_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [$clog2(VERTICES*VERTICES)-1:0]   wr_addr_i,
  input  logic [WEIGHT_BITS-1:0]                 wr_data_i,
  input  logic [$clog2(VERTICES*VERTICES)-1:0]   rd_addr_i,
  output logic [WEIGHT_BITS-1:0]                 rd_data_o,
  output logic                                   clearing_o
);

  localparam int DEPTH     = VERTICES * VERTICES;
  localparam int ADDR_BITS = $clog2(DEPTH);

  logic [WEIGHT_BITS-1:0] mem_q [DEPTH];
  logic [WEIGHT_BITS-1:0] rd_data_q;
  logic                   clearing_q, clearing_d;
  logic [ADDR_BITS-1:0]   clr_addr_q, clr_addr_d;

  // After reset every entry is swept to zero, one per cycle.
  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_BITS'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

### rtl/core/spdg_core.sv
module spdg_core #(
  parameter int VERTICES    = spdg_pkg::DEFAULT_VERTICES,
  parameter int WEIGHT_BITS = spdg_pkg::DEFAULT_WEIGHT_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  spdg_pkg::run_req_t                       run_i,
  output logic                                     idle_o,
  output logic [$clog2(VERTICES*VERTICES)-1:0]     mem_rd_addr_o,
  input  logic [WEIGHT_BITS-1:0]                   mem_rd_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [spdg_pkg::VERTEX_PORT_BITS-1:0]    vertex_index_o,
  output logic [spdg_pkg::DIST_PORT_BITS-1:0]      path_distance_o,
  output logic                                     reachable_o,
  output logic                                     last_result_o
);

  localparam int VIDX_BITS = $clog2(VERTICES);
  localparam int CNT_BITS  = $clog2(VERTICES + 1);
  localparam int ADDR_BITS = $clog2(VERTICES * VERTICES);
  localparam int DB        = spdg_pkg::DIST_BITS;
  localparam int CAND_BITS = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;

  spdg_pkg::state_e state_q, state_d;

  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [VIDX_BITS-1:0] round_q, round_d;
  logic                 pend_q, pend_d;
  logic [VIDX_BITS-1:0] pend_idx_q, pend_idx_d;
  logic [VIDX_BITS-1:0] pick_q, pick_d;
  logic [DB-1:0]        best_q, best_d;
  logic [DB-1:0]        dist_q [VERTICES];
  logic [DB-1:0]        dist_d [VERTICES];
  logic [VERTICES-1:0]  done_q, done_d;

  logic                 out_valid_q, out_valid_d;
  logic [spdg_pkg::VERTEX_PORT_BITS-1:0] vidx_q, vidx_d;
  logic [spdg_pkg::DIST_PORT_BITS-1:0]   pdist_q, pdist_d;
  logic                 reach_q, reach_d;
  logic                 last_q, last_d;

  logic [VIDX_BITS-1:0] cnt_idx;
  logic [VIDX_BITS-1:0] rd_idx;
  logic [DB-1:0]        dist_rd;
  logic [CAND_BITS-1:0] cand;
  logic                 src_ok;
  logic [VIDX_BITS-1:0] src_idx;
  logic                 reach;
  logic [DB-1:0]        shown;

  assign cnt_idx = cnt_q[VIDX_BITS-1:0];
  assign rd_idx  = (state_q == spdg_pkg::ST_RELAX) ? pend_idx_q : cnt_idx;
  assign dist_rd = dist_q[rd_idx];

  // The candidate adder: distance through the picked vertex plus the edge weight.
  assign cand = CAND_BITS'(best_q) + CAND_BITS'(mem_rd_data_i);

  assign src_ok  = int'(run_i.src) < VERTICES;
  assign src_idx = VIDX_BITS'(run_i.src);

  assign mem_rd_addr_o = ADDR_BITS'(pick_q) * ADDR_BITS'(VERTICES) + ADDR_BITS'(cnt_idx);

  assign reach = dist_rd < spdg_pkg::DIST_INF;
  assign shown = !reach ? '0 :
                 (dist_rd > spdg_pkg::DIST_OUT_MAX) ? spdg_pkg::DIST_OUT_MAX : dist_rd;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    round_d     = round_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    pick_d      = pick_q;
    best_d      = best_q;
    dist_d      = dist_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    vidx_d      = vidx_q;
    pdist_d     = pdist_q;
    reach_d     = reach_q;
    last_d      = last_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      spdg_pkg::ST_IDLE: begin
        if (run_i.run) begin
          for (int i = 0; i < VERTICES; i++) begin
            dist_d[i] = (src_ok && src_idx == VIDX_BITS'(i)) ? '0 : spdg_pkg::DIST_INF;
          end
          done_d  = '0;
          round_d = '0;
          cnt_d   = '0;
          best_d  = spdg_pkg::DIST_INF;
          state_d = spdg_pkg::ST_SCAN;
        end
      end

      spdg_pkg::ST_SCAN: begin
        // Strict compare keeps the lowest index on a tie.
        if (!done_q[cnt_idx] && dist_rd < best_q) begin
          best_d = dist_rd;
          pick_d = cnt_idx;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(VERTICES - 1)) begin
          state_d = spdg_pkg::ST_PICK;
        end
      end

      spdg_pkg::ST_PICK: begin
        cnt_d = '0;
        if (best_q == spdg_pkg::DIST_INF) begin
          state_d = spdg_pkg::ST_EMIT;
        end else begin
          done_d[pick_q] = 1'b1;
          state_d        = spdg_pkg::ST_RELAX;
        end
      end

      spdg_pkg::ST_RELAX: begin
        // Reads are issued in the cycle before the update that uses them.
        if (cnt_q != CNT_BITS'(VERTICES)) begin
          cnt_d      = cnt_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = cnt_idx;
        end
        if (pend_q && !done_q[pend_idx_q] && mem_rd_data_i != '0 &&
            cand < CAND_BITS'(dist_rd)) begin
          dist_d[pend_idx_q] = DB'(cand);
        end
        if (pend_q && cnt_q == CNT_BITS'(VERTICES)) begin
          cnt_d = '0;
          if (round_q == VIDX_BITS'(VERTICES - 2)) begin
            state_d = spdg_pkg::ST_EMIT;
          end else begin
            round_d = round_q + 1'b1;
            best_d  = spdg_pkg::DIST_INF;
            state_d = spdg_pkg::ST_SCAN;
          end
        end
      end

      spdg_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          vidx_d      = spdg_pkg::VERTEX_PORT_BITS'(cnt_idx);
          pdist_d     = shown[spdg_pkg::DIST_PORT_BITS-1:0];
          reach_d     = reach;
          last_d      = (cnt_q == CNT_BITS'(VERTICES - 1));
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == CNT_BITS'(VERTICES - 1)) begin
            state_d = spdg_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = spdg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spdg_pkg::ST_IDLE;
      cnt_q       <= '0;
      round_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      round_q     <= round_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    pick_q     <= pick_d;
    best_q     <= best_d;
    dist_q     <= dist_d;
    done_q     <= done_d;
    vidx_q     <= vidx_d;
    pdist_q    <= pdist_d;
    reach_q    <= reach_d;
    last_q     <= last_d;
  end

  assign idle_o          = (state_q == spdg_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign vertex_index_o  = vidx_q;
  assign path_distance_o = pdist_q;
  assign reachable_o     = reach_q;
  assign last_result_o   = last_q;

endmodule

### tb/spdg_route_checker.sv
module spdg_route_checker
  import spdg_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        req_type_i,
  input  logic [VERTEX_PORT_BITS-1:0] from_vertex_i,
  input  logic [VERTEX_PORT_BITS-1:0] to_vertex_i,
  input  logic [WEIGHT_PORT_BITS-1:0] edge_weight_i,
  input  logic [VERTEX_PORT_BITS-1:0] source_vertex_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [VERTEX_PORT_BITS-1:0] vertex_index_i,
  input  logic [DIST_PORT_BITS-1:0]   path_distance_i,
  input  logic                        reachable_i,
  input  logic                        last_result_i,
  output int                          mismatches_o,
  output int                          awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = DEFAULT_VERTICES;
  localparam logic [WEIGHT_PORT_BITS-1:0] WEIGHT_KEEP =
    WEIGHT_PORT_BITS'((1 << DEFAULT_WEIGHT_BITS) - 1);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VERTEX_PORT_BITS-1:0] vertex;
    logic [DIST_PORT_BITS-1:0]   distance;
    logic                        reach;
    logic                        last;
  } route_t;

  logic [WEIGHT_PORT_BITS-1:0] edge_w [NODES][NODES];
  route_t                      route_q [$];
  route_t                      want;
  int                          mismatches;

  // Dijkstra over the mirrored matrix; one distance word per vertex is queued.
  task automatic queue_routes(input logic [VERTEX_PORT_BITS-1:0] src);
    logic [DIST_BITS-1:0] span [NODES];
    logic                 settled [NODES];
    logic [DIST_BITS:0]   cand;
    logic [DIST_BITS-1:0] best;
    int                   pick;
    route_t               r;
    for (int v = 0; v < NODES; v++) begin
      span[v]    = DIST_INF;
      settled[v] = 1'b0;
    end
    if (src < NODES) span[src] = '0;
    for (int round = 0; round < NODES - 1; round++) begin
      pick = -1;
      best = DIST_INF;
      for (int i = 0; i < NODES; i++) begin
        if (!settled[i] && span[i] < best) begin
          best = span[i];
          pick = i;
        end
      end
      // Nothing finite is left to settle, so the search is over.
      if (pick < 0) break;
      settled[pick] = 1'b1;
      for (int v = 0; v < NODES; v++) begin
        if (!settled[v] && edge_w[pick][v] != '0) begin
          cand = span[pick] + edge_w[pick][v];
          if (cand < span[v]) span[v] = cand[DIST_BITS-1:0];
        end
      end
    end
    for (int v = 0; v < NODES; v++) begin
      r.vertex = VERTEX_PORT_BITS'(v);
      r.reach  = span[v] < DIST_INF;
      if (!r.reach) r.distance = '0;
      else if (span[v] > DIST_OUT_MAX) r.distance = DIST_PORT_BITS'(DIST_OUT_MAX);
      else r.distance = DIST_PORT_BITS'(span[v]);
      r.last = (v == NODES - 1);
      route_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        for (int j = 0; j < NODES; j++) edge_w[i][j] = '0;
      end
      route_q.delete();
      mismatches = 0;
      mismatches_o <= 0;
      awaited_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (route_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected distance word: vertex %0d dist %0d reach %0b last %0b",
                     $realtime, vertex_index_i, path_distance_i, reachable_i, last_result_i);
          end
        end else begin
          want = route_q.pop_front();
          if (vertex_index_i !== want.vertex || path_distance_i !== want.distance ||
              reachable_i !== want.reach || last_result_i !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: distance word mismatch: expected vertex %0d dist %0d reach %0b last %0b",
                       $realtime, want.vertex, want.distance, want.reach, want.last);
              $display("%0t:                         got      vertex %0d dist %0d reach %0b last %0b",
                       $realtime, vertex_index_i, path_distance_i, reachable_i, last_result_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i == REQ_RUN) begin
          queue_routes(source_vertex_i);
        end else if (from_vertex_i < NODES && to_vertex_i < NODES) begin
          edge_w[from_vertex_i][to_vertex_i] = edge_weight_i & WEIGHT_KEEP;
        end
      end
      mismatches_o <= mismatches;
      awaited_o    <= route_q.size();
    end
  end

endmodule

### tb/tb_shortest_path_dense_graph_top.sv
module tb_shortest_path_dense_graph_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spdg_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 4;
  localparam int ITEM_TARGET     = 360;
  localparam int MAX_WAIT        = 19;
  localparam int HOLD_OFF_CYCLES = 800;
  localparam int DRAIN_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT  = 8000;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        req_type;
  logic [VERTEX_PORT_BITS-1:0] from_vertex;
  logic [VERTEX_PORT_BITS-1:0] to_vertex;
  logic [WEIGHT_PORT_BITS-1:0] edge_weight;
  logic [VERTEX_PORT_BITS-1:0] source_vertex;
  logic                        out_valid;
  logic                        out_stall;
  logic [VERTEX_PORT_BITS-1:0] vertex_index;
  logic [DIST_PORT_BITS-1:0]   path_distance;
  logic                        reachable;
  logic                        last_result;
  int                          mismatches;
  int                          awaited;

  int items_sent    = 0;
  int send_stretch  = 0;
  bit send_steady   = 1'b0;
  int recv_stretch  = 0;
  bit recv_steady   = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  shortest_path_dense_graph_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .from_vertex_i   (from_vertex),
    .to_vertex_i     (to_vertex),
    .edge_weight_i   (edge_weight),
    .source_vertex_i (source_vertex),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .vertex_index_o  (vertex_index),
    .path_distance_o (path_distance),
    .reachable_o     (reachable),
    .last_result_o   (last_result)
  );

  spdg_route_checker u_route_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .req_type_i      (req_type),
    .from_vertex_i   (from_vertex),
    .to_vertex_i     (to_vertex),
    .edge_weight_i   (edge_weight),
    .source_vertex_i (source_vertex),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .vertex_index_i  (vertex_index),
    .path_distance_i (path_distance),
    .reachable_i     (reachable),
    .last_result_i   (last_result),
    .mismatches_o    (mismatches),
    .awaited_o       (awaited)
  );

  // Waits come in stretches: some stretches run back to back, the rest draw a
  // fresh wait for every word.
  function automatic int draw_wait(inout int stretch, inout bit steady);
    if (stretch == 0) begin
      stretch = $urandom_range(4, 40);
      steady  = ($urandom_range(0, 2) == 0);
    end
    stretch--;
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [WEIGHT_PORT_BITS-1:0] draw_weight();
    if ($urandom_range(0, 1) == 0) return WEIGHT_PORT_BITS'($urandom_range(1, 255));
    return WEIGHT_PORT_BITS'($urandom_range(1, 20));
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic put_word(input req_e kind,
                          input logic [VERTEX_PORT_BITS-1:0] row,
                          input logic [VERTEX_PORT_BITS-1:0] col,
                          input logic [WEIGHT_PORT_BITS-1:0] wt,
                          input logic [VERTEX_PORT_BITS-1:0] src);
    int gap;
    gap = draw_wait(send_stretch, send_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type      <= kind;
    from_vertex   <= row;
    to_vertex     <= col;
    edge_weight   <= wt;
    source_vertex <= src;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_edge(input logic [VERTEX_PORT_BITS-1:0] row,
                            input logic [VERTEX_PORT_BITS-1:0] col,
                            input logic [WEIGHT_PORT_BITS-1:0] wt);
    put_word(REQ_WRITE, row, col, wt, VERTEX_PORT_BITS'($urandom()));
  endtask

  task automatic run_from(input logic [VERTEX_PORT_BITS-1:0] src);
    put_word(REQ_RUN, VERTEX_PORT_BITS'($urandom()), VERTEX_PORT_BITS'($urandom()),
             WEIGHT_PORT_BITS'($urandom()), src);
  endtask

  initial begin
    int                          pick;
    logic [VERTEX_PORT_BITS-1:0] head;
    logic [VERTEX_PORT_BITS-1:0] cur;
    logic [VERTEX_PORT_BITS-1:0] nxt;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    req_type      <= REQ_WRITE;
    from_vertex   <= '0;
    to_vertex     <= '0;
    edge_weight   <= '0;
    source_vertex <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Empty graph: only the source is reachable and the search ends after settling it.
    run_from(4'd0);
    write_edge(4'd0, 4'd15, 8'd255);
    write_edge(4'd15, 4'd0, 8'd1);
    write_edge(4'd0, 4'd1, 8'd1);
    write_edge(4'd1, 4'd15, 8'd1);
    write_edge(4'd15, 4'd15, 8'd7);
    write_edge(4'd3, 4'd3, 8'd0);
    run_from(4'd0);
    run_from(4'd15);
    // Removing the short hop leaves only the heavy direct edge.
    write_edge(4'd0, 4'd1, 8'd0);
    run_from(4'd0);
    // Two equal candidates: the lower index has to be settled first.
    write_edge(4'd0, 4'd2, 8'd5);
    write_edge(4'd0, 4'd3, 8'd5);
    write_edge(4'd2, 4'd4, 8'd1);
    write_edge(4'd3, 4'd4, 8'd1);
    write_edge(4'd4, 4'd14, 8'd128);
    run_from(4'd0);
    run_from(4'd7);
    write_edge(4'd9, 4'd8, 8'd127);
    write_edge(4'd8, 4'd9, 8'd254);
    run_from(4'd8);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        // A chain of random-weight edges gives long multi-hop paths.
        head = VERTEX_PORT_BITS'($urandom());
        cur  = head;
        repeat ($urandom_range(2, 8)) begin
          nxt = VERTEX_PORT_BITS'($urandom());
          write_edge(cur, nxt, draw_weight());
          cur = nxt;
        end
        run_from(($urandom_range(0, 3) == 0) ? VERTEX_PORT_BITS'($urandom()) : head);
      end else if (pick < 13) begin
        repeat ($urandom_range(1, 8)) begin
          write_edge(VERTEX_PORT_BITS'($urandom()), VERTEX_PORT_BITS'($urandom()),
                     draw_weight());
        end
        run_from(VERTEX_PORT_BITS'($urandom()));
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 4)) begin
          write_edge(VERTEX_PORT_BITS'($urandom()), VERTEX_PORT_BITS'($urandom()), '0);
        end
        run_from(VERTEX_PORT_BITS'($urandom()));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          put_word(req_e'($urandom_range(0, 1)), VERTEX_PORT_BITS'($urandom()),
                   VERTEX_PORT_BITS'($urandom()), WEIGHT_PORT_BITS'($urandom()),
                   VERTEX_PORT_BITS'($urandom()));
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("shortest_path_dense_graph_top test passed");
    end else begin
      $display("shortest_path_dense_graph_top test failed");
    end
    $finish;
  end

  // Result side. Twice the stall is held for a long stretch so the block
  // backs up and stalls the sender.
  initial begin
    int wait_n;
    int taken;
    taken = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      wait_n = draw_wait(recv_stretch, recv_steady);
      if (taken == 40 || taken == 520) wait_n = HOLD_OFF_CYCLES;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("shortest_path_dense_graph_top test failed");
    $finish;
  end

endmodule
